/* hdl/fill_and_point_set_sum_table_defines.svh */
// Shared assertion macros for the table checker
`ifndef FILL_AND_POINT_SET_SUM_TABLE_DEFINES_SVH
`define FILL_AND_POINT_SET_SUM_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FPST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpst checker: same-cycle property failed");

// next-cycle implication
`define FPST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpst checker: next-cycle property failed");

`endif

/* hdl/fpst_pkg.sv */
package fpst_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 42;
    localparam int CFG_W   = 11;
    localparam int EPOCH_W = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic             CMD_SET  = 1'b0;
    localparam logic             CMD_FILL = 1'b1;
    localparam logic             REG_ENTRIES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] ENTRIES_IN_USE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } fpst_state_t;

    typedef struct packed {
        logic load;
        logic commit;
        logic sweep;
    } fpst_ctl_t;

    typedef struct packed {
        logic sweep_last;
        logic wrap;
    } fpst_stat_t;

endpackage

/* hdl/fpst_item_if.sv */
interface fpst_item_if
    import fpst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output index, output value, input ready);
    modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

/* hdl/fpst_result_if.sv */
interface fpst_result_if
    import fpst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total;
    logic               bad_index;

    modport source (output valid, output total, output bad_index, input ready);
    modport sink   (input valid, input total, input bad_index, output ready);
endinterface

/* hdl/fpst_dp.sv */
module fpst_dp
    import fpst_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fpst_ctl_t          ctl,
    output fpst_stat_t         stat,
    input  logic               cmd,
    input  logic [INDEX_W-1:0] index,
    input  logic [VALUE_W-1:0] value,
    input  logic [CFG_W-1:0]   entries_in_use,
    output logic [TOTAL_W-1:0] total,
    output logic               bad_index
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;
    localparam int MW = EPOCH_W + VALUE_W;
    localparam int PW = CW + VALUE_W;

    // each word: {epoch tag, value}; tag matching the current epoch marks it valid
    logic [MW-1:0]      mem [ENTRIES];
    logic [MW-1:0]      rd_data_reg;
    logic               op_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [VALUE_W-1:0] fill_value_reg, fill_value_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [AW-1:0]      sweep_addr_reg;
    logic [TOTAL_W-1:0] res_total_reg;
    logic               res_bad_reg;

    logic [XW-1:0]      cfg_x;
    logic [XW-1:0]      count_x;
    logic [CW-1:0]      count;
    logic [PW-1:0]      prod;
    logic [VALUE_W-1:0] old_value;
    logic               is_bad;
    logic               set_ok;
    logic [AW-1:0]      wr_addr;

    always_comb
    begin
        cfg_x     = XW'(entries_in_use);
        count_x   = (cfg_x > XW'(ENTRIES)) ? XW'(ENTRIES) : cfg_x;
        count     = CW'(count_x);
        prod      = PW'(count) * PW'(val_reg);
        old_value = (rd_data_reg[MW-1:VALUE_W] == epoch_reg) ?
                    rd_data_reg[VALUE_W-1:0] : fill_value_reg;
        is_bad    = (op_reg == CMD_SET) && (XW'(idx_reg) >= count_x);
        set_ok    = (op_reg == CMD_SET) && !is_bad;
        wr_addr   = AW'(idx_reg);

        fill_value_next = fill_value_reg;
        total_next      = total_reg;
        epoch_next      = epoch_reg;
        if (op_reg == CMD_FILL)
        begin
            fill_value_next = val_reg;
            total_next      = TOTAL_W'(prod);
            // epoch zero is kept for swept words
            epoch_next      = (epoch_reg == '1) ? EPOCH_W'(1) : epoch_reg + EPOCH_W'(1);
        end
        else if (set_ok)
        begin
            total_next = total_reg + TOTAL_W'(val_reg) - TOTAL_W'(old_value);
        end

        stat.sweep_last = (sweep_addr_reg == AW'(ENTRIES - 1));
        stat.wrap       = (op_reg == CMD_FILL) && (epoch_reg == '1);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sweep)
        begin
            mem[sweep_addr_reg] <= '0;
        end
        else if (ctl.commit && set_ok)
        begin
            mem[wr_addr] <= {epoch_reg, val_reg};
        end
        if (ctl.load)
        begin
            rd_data_reg <= mem[AW'(index)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg  <= cmd;
            idx_reg <= index;
            val_reg <= value;
        end
        if (ctl.commit)
        begin
            res_total_reg <= total_next;
            res_bad_reg   <= is_bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_value_reg <= '0;
            total_reg      <= '0;
            epoch_reg      <= EPOCH_W'(1);
            sweep_addr_reg <= '0;
        end
        else
        begin
            if (ctl.commit)
            begin
                fill_value_reg <= fill_value_next;
                total_reg      <= total_next;
                epoch_reg      <= epoch_next;
            end
            if (ctl.sweep)
            begin
                sweep_addr_reg <= stat.sweep_last ? '0 : sweep_addr_reg + AW'(1);
            end
        end
    end

    assign total     = res_total_reg;
    assign bad_index = res_bad_reg;

endmodule

/* hdl/fpst_ctrl.sv */
module fpst_ctrl
    import fpst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    output logic       result_valid,
    input  logic       result_ready,
    output fpst_ctl_t  ctl,
    input  fpst_stat_t stat
);

    fpst_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        ctl        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                ctl.load   = item_valid;
                if (item_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // wait for the result register to free up
                ctl.commit = !out_valid_reg || result_ready;
                if (ctl.commit)
                begin
                    state_next = stat.wrap ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

/* hdl/fill_and_point_set_sum_table.sv */
// Value table with a running total of its first entries_in_use entries. A set
// command (cmd 0) writes one entry and moves the total by the difference; a fill
// (cmd 1) gives every entry the value and sets the total to count * value. Each
// command returns one result beat with the total and a bad_index flag for a set
// beyond the count. A command reads the single-port table memory in the idle
// state, then updates the total and writes back in the update state; it stays
// there while the result register still holds an untaken beat. Entry validity
// is an epoch tag stored with each word, so a fill is one step. After reset,
// and after every 65535th fill when the epoch wraps, a clearing pass sweeps
// every word of the memory and no command is taken meanwhile. Configuration
// writes go through at any time.
module fill_and_point_set_sum_table
    import fpst_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    fpst_item_if.sink          item,
    fpst_result_if.source      result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CFG_W-1:0] entries_in_use_reg;
    logic             reg_sel;
    fpst_ctl_t        ctl;
    fpst_stat_t       stat;

    assign reg_sel = (paddr[PADDR_W-1] == REG_ENTRIES_IN_USE);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? PDATA_W'(entries_in_use_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= ENTRIES_IN_USE_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            entries_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    fpst_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .ctl          (ctl),
        .stat         (stat)
    );

    fpst_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (item.cmd),
        .index          (item.index),
        .value          (item.value),
        .entries_in_use (entries_in_use_reg),
        .total          (result.total),
        .bad_index      (result.bad_index)
    );

endmodule

/* hdl/fpst_checker.sv */
`include "fill_and_point_set_sum_table_defines.svh"

module fpst_checker
    import fpst_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [TOTAL_W-1:0] out_total,
    input logic               out_bad
);

    logic               in_beat;
    logic               out_beat;
    logic [1:0]         pending_reg, pending_next;
    logic [TOTAL_W-1:0] last_total_reg;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_beat && out_beat)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_total_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_beat)
            begin
                last_total_reg <= out_total;
            end
        end
    end

    // a rejected set leaves the total where the previous beat had it
    `FPST_ASSERT_IMP(a_bad_keeps_total, out_beat && out_bad, out_total == last_total_reg)
    // no result beat without an accepted command behind it
    `FPST_ASSERT_IMP(a_no_spurious_out, out_valid, pending_reg != 2'd0)
    // at most one command in work besides a waiting result
    `FPST_ASSERT_IMP(a_one_in_flight, in_beat, pending_reg <= 2'd1)
    `FPST_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_total))

endmodule

bind fill_and_point_set_sum_table fpst_checker u_fpst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_total (result.total),
    .out_bad   (result.bad_index)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import fpst_pkg::*;

    localparam int TABLE_DEPTH   = 1024;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    // register i sits at byte address 4*i; the one past the list must be ignored
    localparam logic [PADDR_W-1:0] ADDR_ENTRIES   = PADDR_W'(4 * REG_ENTRIES_IN_USE);
    localparam logic [PADDR_W-1:0] ADDR_PAST_LAST = PADDR_W'(4 * (REG_ENTRIES_IN_USE + 1));

    typedef struct {
        logic               cmd;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } table_cmd_t;

    typedef struct {
        logic [TOTAL_W-1:0] total;
        logic               bad_index;
    } total_beat_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    fpst_item_if   item ();
    fpst_result_if result ();

    fill_and_point_set_sum_table #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the table
    logic [VALUE_W-1:0] shadow_val [TABLE_DEPTH];
    bit                 shadow_set [TABLE_DEPTH];
    logic [VALUE_W-1:0] shadow_fill;
    logic [TOTAL_W-1:0] shadow_total;
    logic [CFG_W-1:0]   shadow_count;

    table_cmd_t  cmds_pending [$];
    total_beat_t totals_due [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          beat_taken = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    int          stall_pos = 0;

    function automatic int live_entries();
        return (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    endfunction

    function automatic total_beat_t apply_command(table_cmd_t c);
        logic [TOTAL_W-1:0] live;
        logic [VALUE_W-1:0] prior;
        total_beat_t        beat;
        live = TOTAL_W'(live_entries());
        beat.bad_index = 1'b0;
        if (c.cmd == CMD_FILL)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                shadow_set[i] = 1'b0;
            shadow_fill  = c.value;
            shadow_total = live * {10'd0, c.value};
        end
        else if (TOTAL_W'(c.index) < live)
        begin
            prior = shadow_set[c.index] ? shadow_val[c.index] : shadow_fill;
            shadow_total = shadow_total + {10'd0, c.value} - {10'd0, prior};
            shadow_val[c.index] = c.value;
            shadow_set[c.index] = 1'b1;
        end
        else
        begin
            beat.bad_index = 1'b1;
        end
        beat.total = shadow_total;
        return beat;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // monitor: check result beats, predict accepted commands
    always @(posedge clk)
    begin
        total_beat_t want;
        table_cmd_t  got;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (totals_due.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual total=%0d bad_index=%0b",
                             $time, result.total, result.bad_index);
                    mismatches++;
                end
                else
                begin
                    want = totals_due.pop_front();
                    if (result.total !== want.total)
                    begin
                        $display("%0t: total expected %0d actual %0d",
                                 $time, want.total, result.total);
                        mismatches++;
                    end
                    if (result.bad_index !== want.bad_index)
                    begin
                        $display("%0t: bad_index expected %0b actual %0b",
                                 $time, want.bad_index, result.bad_index);
                        mismatches++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                got.cmd   = item.cmd;
                got.index = item.index;
                got.value = item.value;
                totals_due.insert(totals_due.size(), apply_command(got));
                beat_taken = 1'b1;
            end
        end
    end

    // driver: bursts of beats with random gaps
    always @(negedge clk)
    begin
        table_cmd_t nxt;
        if (rst_n && !(item.valid && !beat_taken))
        begin
            beat_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                item.valid <= 1'b0;
            end
            else if (cmds_pending.size() > 0)
            begin
                nxt = cmds_pending.pop_front();
                item.valid <= 1'b1;
                item.cmd   <= nxt.cmd;
                item.index <= nxt.index;
                item.value <= nxt.value;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if ($urandom_range(0, 15) == 0)
                        gap_left = $urandom_range(10, 30);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                item.valid <= 1'b0;
            end
        end
    end

    // receiver: ready pattern from a 16-bit word, redrawn each time it runs out
    always @(negedge clk)
    begin
        if (stall_pos == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pat = 16'hFFFF;
                1:       stall_pat = 16'($urandom);
                2:       stall_pat = 16'($urandom | $urandom);
                default: stall_pat = 16'($urandom & $urandom);
            endcase
        end
        result.ready <= stall_pat[stall_pos];
        stall_pos = (stall_pos + 1) % 16;
    end

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_ENTRIES)
            shadow_count = data[CFG_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // count write, half of the time with junk in the unused upper bits
    task automatic set_entries(int count);
        logic [PDATA_W-1:0] data;
        data = PDATA_W'(count);
        if ($urandom_range(0, 1))
            data = data | ($urandom & ~PDATA_W'(2 ** CFG_W - 1));
        reg_write(ADDR_ENTRIES, data);
    endtask

    task automatic queue_cmd(logic cmd, int index, logic [VALUE_W-1:0] value);
        table_cmd_t c;
        c.cmd   = cmd;
        c.index = INDEX_W'(index);
        c.value = value;
        cmds_pending.insert(cmds_pending.size(), c);
    endtask

    task automatic queue_random(int n);
        int         live;
        table_cmd_t c;
        live = live_entries();
        repeat (n)
        begin
            c.cmd = ($urandom_range(0, 9) == 0) ? CMD_FILL : CMD_SET;
            case ($urandom_range(0, 9))
                0:       c.index = INDEX_W'($urandom);
                1:       c.index = (live < TABLE_DEPTH) ?
                                   INDEX_W'($urandom_range(live, TABLE_DEPTH - 1)) :
                                   INDEX_W'($urandom);
                2, 3:    c.index = (live == 0) ? INDEX_W'($urandom) :
                                   INDEX_W'($urandom_range(0, ((live < 8) ? live : 8) - 1));
                default: c.index = (live == 0) ? INDEX_W'($urandom) :
                                   INDEX_W'($urandom_range(0, live - 1));
            endcase
            case ($urandom_range(0, 7))
                0:       c.value = '0;
                1:       c.value = '1;
                2:       c.value = VALUE_W'($urandom_range(0, 15));
                default: c.value = $urandom;
            endcase
            cmds_pending.insert(cmds_pending.size(), c);
        end
    endtask

    task automatic drain();
        do @(posedge clk);
        while (cmds_pending.size() != 0 || item.valid || totals_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        item.valid   = 1'b0;
        item.cmd     = CMD_SET;
        item.index   = '0;
        item.value   = '0;
        result.ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rst_n        = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            shadow_set[i] = 1'b0;
        shadow_fill  = '0;
        shadow_total = '0;
        shadow_count = ENTRIES_IN_USE_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset count: extremes of index and value, overwrite, fill then set
        queue_cmd(CMD_SET, 0, '1);
        queue_cmd(CMD_SET, TABLE_DEPTH - 1, '1);
        queue_cmd(CMD_SET, 0, '0);
        queue_cmd(CMD_SET, 512, 1);
        queue_cmd(CMD_FILL, 341, '1);
        queue_cmd(CMD_SET, 5, '0);
        queue_cmd(CMD_SET, 5, 123);
        queue_cmd(CMD_FILL, 682, '0);
        queue_cmd(CMD_SET, TABLE_DEPTH - 1, 7);
        drain();

        // write past the register list: count must stay put
        reg_write(ADDR_PAST_LAST, 32'd5);
        queue_cmd(CMD_SET, 1000, 9);
        drain();

        // shrink, fill, grow back: kept total goes below zero and wraps up again
        set_entries(1);
        queue_cmd(CMD_FILL, 0, 32'h8000_0000);
        drain();
        set_entries(TABLE_DEPTH);
        queue_cmd(CMD_SET, 5, '0);
        queue_cmd(CMD_SET, 6, '0);
        queue_cmd(CMD_SET, 7, '1);
        drain();

        // index just at and beyond the count
        set_entries(10);
        queue_cmd(CMD_SET, 10, 3);
        queue_cmd(CMD_SET, 9, 4);
        queue_cmd(CMD_SET, TABLE_DEPTH - 1, 5);
        queue_cmd(CMD_FILL, 0, '1);
        drain();

        // no entry in use
        reg_write(ADDR_ENTRIES, 32'd0);
        queue_cmd(CMD_SET, 0, 1);
        queue_cmd(CMD_FILL, 0, '1);
        queue_cmd(CMD_SET, TABLE_DEPTH - 1, '1);
        drain();

        // count above table size saturates
        reg_write(ADDR_ENTRIES, '1);
        queue_cmd(CMD_FILL, 0, '1);
        queue_cmd(CMD_SET, TABLE_DEPTH - 1, '0);
        drain();

        set_entries(TABLE_DEPTH);
        queue_random(90);
        drain();
        set_entries(1);
        queue_random(70);
        drain();
        set_entries(2);
        queue_random(70);
        drain();
        set_entries($urandom_range(3, TABLE_DEPTH - 1));
        queue_random(90);
        drain();
        set_entries(2 ** CFG_W - 1);
        queue_random(80);
        drain();
        set_entries(0);
        queue_random(30);
        drain();
        set_entries($urandom_range(TABLE_DEPTH + 1, 2 ** CFG_W - 2));
        queue_random(80);
        drain();
        set_entries($urandom_range(1, TABLE_DEPTH - 1));
        queue_random(80);
        drain();
        set_entries(TABLE_DEPTH - 1);
        queue_random(70);
        drain();
        set_entries(TABLE_DEPTH);
        queue_random(90);
        drain();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
